[design/lcs_pkg.sv]
// lcs_pkg.sv: shared types, character codes and helpers for the comment scanner
`timescale 1ns / 1ps
`default_nettype none

package lcs_pkg;

    // counter widths
    localparam int LEVEL_BITS  = 8;
    localparam int LENGTH_BITS = 16;
    localparam int LINE_BITS   = 20;
    localparam int SUM_BITS    = ((LENGTH_BITS > LEVEL_BITS) ? LENGTH_BITS : LEVEL_BITS) + 2;

    // source characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    // scanner phase
    typedef enum logic [3:0] {
        PH_DASH1   = 4'd0,
        PH_DASH2   = 4'd1,
        PH_OPEN    = 4'd2,
        PH_OPEN_EQ = 4'd3,
        PH_LINE    = 4'd4,
        PH_BLOCK   = 4'd5,
        PH_CLOSE   = 4'd6
    } t_phase;

    // result kind
    typedef enum logic [1:0] {
        KIND_LINE     = 2'd0,
        KIND_BLOCK    = 2'd1,
        KIND_BROKEN   = 2'd2,
        KIND_NOT_DASH = 2'd3
    } t_kind;

    typedef struct packed {
        t_phase                 phase;
        logic [LEVEL_BITS-1:0]  open_level;
        logic [LEVEL_BITS-1:0]  close_run;
        logic [LENGTH_BITS-1:0] text;
        logic [LINE_BITS-1:0]   line;
        logic [LENGTH_BITS-1:0] col;
    } t_state;

    typedef struct packed {
        t_kind                  kind;
        logic [LENGTH_BITS-1:0] body;
        logic [LINE_BITS-1:0]   line;
        logic [LENGTH_BITS-1:0] col;
        logic                   kept;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:      PH_DASH1,
        open_level: '0,
        close_run:  '0,
        text:       '0,
        line:       '0,
        col:        '0
    };

    // saturating increment of a length or column count
    function automatic logic [LENGTH_BITS-1:0] len_inc(input logic [LENGTH_BITS-1:0] v);
        return (v == {LENGTH_BITS{1'b1}}) ? v : v + LENGTH_BITS'(1);
    endfunction

    // saturating increment of an equals-run count
    function automatic logic [LEVEL_BITS-1:0] lvl_inc(input logic [LEVEL_BITS-1:0] v);
        return (v == {LEVEL_BITS{1'b1}}) ? v : v + LEVEL_BITS'(1);
    endfunction

endpackage

`default_nettype wire

[design/lcs_step.sv]
// lcs_step.sv: per-byte next-state and result logic of the comment scanner
`timescale 1ns / 1ps
`default_nettype none

module lcs_step import lcs_pkg::*; (
    input  wire t_state     i_state,
    input  wire logic [7:0] i_char_byte,
    input  wire logic       i_at_end,
    output t_state          o_next,
    output logic            o_emit,
    output t_result         o_result
);

    logic                   w_stop;
    logic [SUM_BITS-1:0]    w_close_sum;
    logic [LENGTH_BITS-1:0] w_close_text;
    logic                   w_as_line;
    t_kind                  w_kind;
    logic [LENGTH_BITS-1:0] w_body;
    logic                   w_kept;

    assign w_stop = i_at_end || (i_char_byte == CH_NUL);

    // failed close attempt: bracket plus equals run go back into the body text
    assign w_close_sum = SUM_BITS'(i_state.text) + SUM_BITS'(i_state.close_run) + SUM_BITS'(1);
    assign w_close_text = (w_close_sum > SUM_BITS'({LENGTH_BITS{1'b1}}))
                        ? {LENGTH_BITS{1'b1}} : w_close_sum[LENGTH_BITS-1:0];

    // next state and result
    always_comb begin
        o_next    = i_state;
        o_emit    = 1'b0;
        w_as_line = 1'b0;
        w_kind    = KIND_LINE;
        w_body    = '0;
        w_kept    = !i_at_end;

        unique case (i_state.phase)
            PH_DASH2: begin
                if (!i_at_end && i_char_byte == CH_DASH) begin
                    o_next.col   = len_inc(i_state.col);
                    o_next.phase = PH_OPEN;
                end else begin
                    o_emit = 1'b1;
                    w_kind = KIND_NOT_DASH;
                end
            end
            PH_OPEN: begin
                if (!i_at_end && i_char_byte == CH_LBRACK) begin
                    o_next.col        = len_inc(i_state.col);
                    o_next.text       = len_inc(i_state.text);
                    o_next.open_level = '0;
                    o_next.phase      = PH_OPEN_EQ;
                end else begin
                    o_next.phase = PH_LINE;
                    w_as_line    = 1'b1;
                end
            end
            PH_OPEN_EQ: begin
                if (!i_at_end && i_char_byte == CH_EQ) begin
                    o_next.col        = len_inc(i_state.col);
                    o_next.text       = len_inc(i_state.text);
                    o_next.open_level = lvl_inc(i_state.open_level);
                end else if (!i_at_end && i_char_byte == CH_LBRACK) begin
                    o_next.col       = len_inc(i_state.col);
                    o_next.text      = '0;
                    o_next.close_run = '0;
                    o_next.phase     = PH_BLOCK;
                end else begin
                    o_next.phase = PH_LINE;
                    w_as_line    = 1'b1;
                end
            end
            PH_LINE: begin
                w_as_line = 1'b1;
            end
            PH_CLOSE: begin
                if (!i_at_end && i_char_byte == CH_EQ) begin
                    o_next.col       = len_inc(i_state.col);
                    o_next.close_run = lvl_inc(i_state.close_run);
                end else if (!i_at_end && i_char_byte == CH_RBRACK) begin
                    o_next.col = len_inc(i_state.col);
                    if (i_state.close_run == i_state.open_level) begin
                        o_emit = 1'b1;
                        w_kind = KIND_BLOCK;
                        w_body = i_state.text;
                        w_kept = 1'b0;
                    end else begin
                        o_next.text      = w_close_text;
                        o_next.close_run = '0;
                    end
                end else begin
                    o_next.close_run = '0;
                    o_next.phase     = PH_BLOCK;
                    if (w_stop) begin
                        o_emit = 1'b1;
                        w_kind = KIND_BROKEN;
                    end else begin
                        o_next.text = len_inc(w_close_text);
                        if (i_char_byte == CH_LF) begin
                            o_next.line = i_state.line + LINE_BITS'(1);
                            o_next.col  = '0;
                        end else begin
                            o_next.col = len_inc(i_state.col);
                        end
                    end
                end
            end
            PH_BLOCK: begin
                if (w_stop) begin
                    o_emit = 1'b1;
                    w_kind = KIND_BROKEN;
                end else if (i_char_byte == CH_RBRACK) begin
                    o_next.col       = len_inc(i_state.col);
                    o_next.close_run = '0;
                    o_next.phase     = PH_CLOSE;
                end else begin
                    o_next.text = len_inc(i_state.text);
                    if (i_char_byte == CH_LF) begin
                        o_next.line = i_state.line + LINE_BITS'(1);
                        o_next.col  = '0;
                    end else begin
                        o_next.col = len_inc(i_state.col);
                    end
                end
            end
            default: begin
                // first dash, also any unused phase code
                if (!i_at_end && i_char_byte == CH_DASH) begin
                    o_next.col   = len_inc(i_state.col);
                    o_next.phase = PH_DASH2;
                end else begin
                    o_emit = 1'b1;
                    w_kind = KIND_NOT_DASH;
                end
            end
        endcase

        // line comment body: ends before cr, lf or nul, or at end of input
        if (w_as_line) begin
            if (w_stop || i_char_byte == CH_CR || i_char_byte == CH_LF) begin
                o_emit = 1'b1;
                w_kind = KIND_LINE;
                w_body = o_next.text;
            end else begin
                o_next.col  = len_inc(o_next.col);
                o_next.text = len_inc(o_next.text);
            end
        end

        // result carries position after this byte, then scanner rearms
        o_result.kind = w_kind;
        o_result.body = w_body;
        o_result.line = o_next.line;
        o_result.col  = o_next.col;
        o_result.kept = w_kept;
        if (o_emit) begin
            o_next = STATE_RESET;
        end
    end

endmodule

`default_nettype wire

[design/lua_comment_scanner.sv]
// lua_comment_scanner.sv: top level of the comment scanner, handshake and registers
//
// Usage: feed one comment token as a byte stream, starting at its first dash.
// Input channel: i_in_valid / o_in_stall carry i_char_byte and i_at_end; set
// i_at_end when the source is exhausted (the byte is then ignored), a nul byte
// also ends the comment. Output channel: o_out_valid / i_out_stall carry one
// result transaction per finished comment (kind, body length, end line and
// column, and whether the last byte was left unconsumed). After a result the
// scanner rearms at once for the next comment.
// Throughput: one byte per cycle while no result is held under i_out_stall; the
// per-byte state update is a single pass of logic between the input register
// and the state/result registers. The byte that ends a comment passes the input
// register, and its result is then registered in the result register.
// Stall: while a result waits under i_out_stall, a byte already in the input
// register is held and o_in_stall rises; bytes flow again the cycle the result
// is taken. Reset (synchronous, active low) empties both registers and returns
// the scanner to expecting the first dash.
`timescale 1ns / 1ps
`default_nettype none

module lua_comment_scanner import lcs_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [7:0]             i_char_byte,
    input  wire logic                   i_at_end,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [1:0]                  o_kind,
    output logic [LENGTH_BITS-1:0]      o_body_length,
    output logic [LINE_BITS-1:0]        o_end_line,
    output logic [LENGTH_BITS-1:0]      o_end_column,
    output logic                        o_byte_kept
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    t_result    r_out;
    t_result    w_res;
    logic       w_emit;
    logic       w_out_busy;
    logic       w_fire;

    // handshake control
    assign w_out_busy = r_out_valid && i_out_stall;
    assign w_fire     = r_in_valid && !w_out_busy;
    assign o_in_stall = r_in_valid && w_out_busy;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_char_byte;
            r_in_end  <= i_at_end;
        end
    end

    // per-byte scan logic
    lcs_step u_step (
        .i_state     (r_state),
        .i_char_byte (r_in_byte),
        .i_at_end    (r_in_end),
        .o_next      (n_state),
        .o_emit      (w_emit),
        .o_result    (w_res)
    );

    // scanner state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (w_fire) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!w_out_busy) begin
            r_out_valid <= w_fire && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out.kind;
    assign o_body_length = r_out.body;
    assign o_end_line    = r_out.line;
    assign o_end_column  = r_out.col;
    assign o_byte_kept   = r_out.kept;

`ifndef ASSERT_OFF
    // input side only stalls behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled without a pending result");

    // every emitted result rearms the scanner
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_emit) |=> (r_state.phase == PH_DASH1))
        else $error("scanner not rearmed after a result");

    // a closed block always consumes its final bracket
    a_block_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_BLOCK) |-> !o_byte_kept)
        else $error("closed block reports kept byte");

    // unfinished blocks and bad starts carry no body
    a_empty_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_BROKEN || o_kind == KIND_NOT_DASH))
        |-> (o_body_length == '0))
        else $error("nonzero body on broken or bad-start result");
`endif

endmodule

`default_nettype wire

[tb/tb_lua_comment_scanner.sv]
// tb_lua_comment_scanner.sv: self-checking testbench for the comment scanner
`timescale 1ns / 1ps

module tb_lua_comment_scanner;
    import lcs_pkg::*;

    // receiver stall modes
    localparam logic [1:0] STALL_NONE     = 2'd0;
    localparam logic [1:0] STALL_LIGHT    = 2'd1;
    localparam logic [1:0] STALL_HEAVY    = 2'd2;
    localparam logic [1:0] STALL_PERIODIC = 2'd3;

    localparam int RANDOM_BYTES = 500;
    localparam int SETTLE_CYCLES = 10;

    // scoreboard: tracks the scanner state and queues the comment results it predicts
    class comment_scoreboard;
        t_phase                 phase;
        logic [LEVEL_BITS-1:0]  open_level;
        logic [LEVEL_BITS-1:0]  close_run;
        logic [LENGTH_BITS-1:0] text_len;
        logic [LINE_BITS-1:0]   line_no;
        logic [LENGTH_BITS-1:0] col_no;
        t_result                comments_due[$];
        int                     mismatches;
        int                     comments_seen;
        int                     kinds_seen[4];

        function new();
            mismatches    = 0;
            comments_seen = 0;
            foreach (kinds_seen[k]) kinds_seen[k] = 0;
            rearm();
        endfunction

        function void rearm();
            phase      = PH_DASH1;
            open_level = '0;
            close_run  = '0;
            text_len   = '0;
            line_no    = '0;
            col_no     = '0;
        endfunction

        function int pending();
            return comments_due.size();
        endfunction

        function logic [LENGTH_BITS-1:0] add_len(input logic [LENGTH_BITS-1:0] v,
                                                  input logic [LEVEL_BITS:0] a);
            logic [LENGTH_BITS:0] s;
            s = {1'b0, v} + a;
            return s[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : s[LENGTH_BITS-1:0];
        endfunction

        function logic [LEVEL_BITS-1:0] lvl_up(input logic [LEVEL_BITS-1:0] v);
            return (v == {LEVEL_BITS{1'b1}}) ? v : v + 1'b1;
        endfunction

        function void col_up();
            if (col_no != {LENGTH_BITS{1'b1}}) col_no = col_no + 1'b1;
        endfunction

        function void finish_comment(input t_kind k, input logic [LENGTH_BITS-1:0] body,
                                     input logic kept);
            t_result r;
            r.kind = k;
            r.body = body;
            r.line = line_no;
            r.col  = col_no;
            r.kept = kept;
            comments_due = {comments_due, r};
            rearm();
        endfunction

        // line comment body: CR, LF and nul leave the byte unconsumed
        function void line_text(input logic [7:0] b, input logic stop, input logic kept);
            if (stop || b == CH_CR || b == CH_LF) begin
                finish_comment(KIND_LINE, text_len, kept);
            end else begin
                col_up();
                text_len = add_len(text_len, (LEVEL_BITS+1)'(1));
            end
        endfunction

        // block comment body byte; LF starts a new line
        function void block_text(input logic [7:0] b, input logic stop, input logic kept);
            if (stop) begin
                finish_comment(KIND_BROKEN, '0, kept);
            end else begin
                if (b == CH_LF) begin
                    line_no = line_no + 1'b1;
                    col_no  = '0;
                end else begin
                    col_up();
                end
                text_len = add_len(text_len, (LEVEL_BITS+1)'(1));
            end
        endfunction

        // advance the scanner by one accepted byte
        function void note_byte(input logic [7:0] b, input logic at_end);
            logic stop;
            logic kept;
            stop = at_end || (b == CH_NUL);
            kept = !at_end;
            case (phase)
                PH_DASH2: begin
                    if (!at_end && b == CH_DASH) begin
                        col_up();
                        phase = PH_OPEN;
                    end else begin
                        finish_comment(KIND_NOT_DASH, '0, kept);
                    end
                end
                PH_OPEN: begin
                    if (!at_end && b == CH_LBRACK) begin
                        col_up();
                        text_len   = add_len(text_len, (LEVEL_BITS+1)'(1));
                        open_level = '0;
                        phase      = PH_OPEN_EQ;
                    end else begin
                        phase = PH_LINE;
                        line_text(b, stop, kept);
                    end
                end
                PH_OPEN_EQ: begin
                    if (!at_end && b == CH_EQ) begin
                        col_up();
                        text_len   = add_len(text_len, (LEVEL_BITS+1)'(1));
                        open_level = lvl_up(open_level);
                    end else if (!at_end && b == CH_LBRACK) begin
                        col_up();
                        text_len  = '0;
                        close_run = '0;
                        phase     = PH_BLOCK;
                    end else begin
                        phase = PH_LINE;
                        line_text(b, stop, kept);
                    end
                end
                PH_LINE: line_text(b, stop, kept);
                PH_CLOSE: begin
                    if (!at_end && b == CH_EQ) begin
                        col_up();
                        close_run = lvl_up(close_run);
                    end else if (!at_end && b == CH_RBRACK) begin
                        col_up();
                        if (close_run == open_level) begin
                            finish_comment(KIND_BLOCK, text_len, 1'b0);
                        end else begin
                            // failed close: the bracket and equals become text
                            text_len  = add_len(text_len, {1'b0, close_run} + 1'b1);
                            close_run = '0;
                        end
                    end else begin
                        text_len  = add_len(text_len, {1'b0, close_run} + 1'b1);
                        close_run = '0;
                        phase     = PH_BLOCK;
                        block_text(b, stop, kept);
                    end
                end
                PH_BLOCK: begin
                    if (!stop && b == CH_RBRACK) begin
                        col_up();
                        close_run = '0;
                        phase     = PH_CLOSE;
                    end else begin
                        block_text(b, stop, kept);
                    end
                end
                default: begin
                    if (!at_end && b == CH_DASH) begin
                        col_up();
                        phase = PH_DASH2;
                    end else begin
                        finish_comment(KIND_NOT_DASH, '0, kept);
                    end
                end
            endcase
        endfunction

        // compare one result transaction with the oldest prediction
        function void check_comment(input t_result got);
            t_result want;
            if (comments_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d body %0d line %0d col %0d kept %0d",
                             got.kind, got.body, got.line, got.col, got.kept);
                return;
            end
            want = comments_due.pop_front();
            comments_seen++;
            kinds_seen[want.kind]++;
            if (got.kind !== want.kind || got.body !== want.body || got.line !== want.line ||
                got.col !== want.col || got.kept !== want.kept) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp kind %0d body %0d line %0d col %0d kept %0d,",
                              " got kind %0d body %0d line %0d col %0d kept %0d"},
                             want.kind, want.body, want.line, want.col, want.kept,
                             got.kind, got.body, got.line, got.col, got.kept);
            end
        endfunction
    endclass

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic [7:0]             i_char_byte = 8'h00;
    logic                   i_at_end    = 1'b0;
    logic                   i_out_stall = 1'b0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [1:0]             o_kind;
    logic [LENGTH_BITS-1:0] o_body_length;
    logic [LINE_BITS-1:0]   o_end_line;
    logic [LENGTH_BITS-1:0] o_end_column;
    logic                   o_byte_kept;

    logic [5:0]             stall_cnt  = '0;
    logic [1:0]             stall_mode = STALL_NONE;

    comment_scoreboard sb;
    int bytes_sent = 0;
    int burst_left = 1;
    int drains     = 0;

    lua_comment_scanner u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_char_byte   (i_char_byte),
        .i_at_end      (i_at_end),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_body_length (o_body_length),
        .o_end_line    (o_end_line),
        .o_end_column  (o_end_column),
        .o_byte_kept   (o_byte_kept)
    );

    always #5 i_clk = ~i_clk;

    // receiver stall pattern, mode redrawn each time the 6-bit stall counter wraps
    always @(posedge i_clk) begin
        stall_cnt <= stall_cnt + 1'b1;
        if (stall_cnt == '0) stall_mode <= 2'($urandom_range(0, 3));
        case (stall_mode)
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    i_out_stall <= ($urandom_range(0, 9) < 7);
            STALL_PERIODIC: i_out_stall <= (stall_cnt[2:0] < 3'd3);
            default:        i_out_stall <= 1'b0;
        endcase
    end

    // result monitor
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.kind = t_kind'(o_kind);
            got.body = o_body_length;
            got.line = o_end_line;
            got.col  = o_end_column;
            got.kept = o_byte_kept;
            sb.check_comment(got);
        end
    end

    // one input transaction, then a random gap when the burst runs out
    task automatic drive_byte(input logic [7:0] b, input logic at_end);
        int gap;
        i_in_valid  <= 1'b1;
        i_char_byte <= b;
        i_at_end    <= at_end;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_byte(b, at_end);
        bytes_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 400)
                                                     : $urandom_range(1, 30);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) drive_byte(s[i], 1'b0);
    endtask

    task automatic send_run(input logic [7:0] b, input int n);
        repeat (n) drive_byte(b, 1'b0);
    endtask

    // hold the sender until every predicted result has come out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        drains++;
    endtask

    function automatic logic [7:0] text_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    // body bytes biased toward brackets, equals and newlines
    function automatic logic [7:0] body_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return CH_RBRACK;
        if (r < 30) return CH_EQ;
        if (r < 38) return CH_LF;
        if (r < 42) return CH_LBRACK;
        if (r < 45) return CH_CR;
        return text_byte();
    endfunction

    function automatic logic [7:0] line_byte();
        logic [7:0] b;
        do b = text_byte(); while (b == CH_CR || b == CH_LF);
        return b;
    endfunction

    // stop the comment by end of input or a nul byte
    task automatic send_stop();
        if ($urandom_range(0, 1) == 0) drive_byte(8'($urandom_range(0, 255)), 1'b1);
        else drive_byte(CH_NUL, 1'b0);
    endtask

    task automatic send_block_comment();
        int level;
        int r;
        level = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 3);
        send_text("--[");
        send_run(CH_EQ, level);
        drive_byte(CH_LBRACK, 1'b0);
        repeat ($urandom_range(0, 30)) drive_byte(body_byte(), 1'b0);
        r = $urandom_range(0, 99);
        if (r < 88) begin
            if (r >= 78) begin
                // a close with the wrong level first
                drive_byte(CH_RBRACK, 1'b0);
                send_run(CH_EQ, level + 1);
                drive_byte(CH_RBRACK, 1'b0);
                repeat ($urandom_range(0, 4)) drive_byte(body_byte(), 1'b0);
            end
            drive_byte(CH_RBRACK, 1'b0);
            send_run(CH_EQ, level);
            drive_byte(CH_RBRACK, 1'b0);
        end else if (r < 95) begin
            send_stop();
        end
    endtask

    task automatic send_line_comment();
        int r;
        send_text("--");
        if ($urandom_range(0, 9) < 3) begin
            drive_byte(CH_LBRACK, 1'b0);
            send_run(CH_EQ, $urandom_range(0, 3));
        end
        repeat ($urandom_range(0, 30)) drive_byte(line_byte(), 1'b0);
        r = $urandom_range(0, 3);
        case (r)
            0:       drive_byte(CH_CR, 1'b0);
            1:       drive_byte(CH_LF, 1'b0);
            default: send_stop();
        endcase
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4))
            drive_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    endtask

    initial begin
        int target;
        int r;
        sb = new();
        burst_left = $urandom_range(1, 30);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: level-one block with a failed close, broken opener, bad second
        // dash, end on the first byte, unfinished block ended by nul
        send_text("--[=[a]]=]");
        send_text("--[=x");
        drive_byte(CH_LF, 1'b0);
        send_text("-x");
        drive_byte(8'hFF, 1'b1);
        send_text("--[[");
        drive_byte(CH_LF, 1'b0);
        drive_byte(CH_NUL, 1'b0);
        drain_results();

        // saturated open against a shorter close, then a longer saturated close
        send_text("--[");
        send_run(CH_EQ, 256);
        send_text("[x]");
        send_run(CH_EQ, 254);
        drive_byte(CH_RBRACK, 1'b0);
        send_run(CH_EQ, 260);
        drive_byte(CH_RBRACK, 1'b0);
        drain_results();

        // random comment stream
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 8) send_noise();
            else if (r < 70) send_block_comment();
            else send_line_comment();
            if ($urandom_range(0, 19) == 0) drain_results();
        end
        send_stop();

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("ran %0d bytes into %0d comments: %0d line, %0d block,",
                 bytes_sent, sb.comments_seen, sb.kinds_seen[KIND_LINE],
                 sb.kinds_seen[KIND_BLOCK]);
        $display("%0d unfinished, %0d rejected; sender drained %0d times, %0d mismatches",
                 sb.kinds_seen[KIND_BROKEN], sb.kinds_seen[KIND_NOT_DASH],
                 drains, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("[lua_comment_scanner] OK");
        end else begin
            $display("[lua_comment_scanner] ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("[lua_comment_scanner] ERROR");
        $finish;
    end

endmodule
